>>> hdl/fts_pkg.sv
// types, constants and register codes shared by the target follower files
`timescale 1ns / 1ps
`default_nettype none
package fts_pkg;
    localparam int COORD_BITS_DEF = 15;
    localparam int SPAN_W = 13;
    localparam int OFS_W = 13;
    localparam int SPD_W = 8;
    localparam int ANG_W = 4;
    localparam int DVD_W = 20;
    localparam int CNT_W = 5;
    localparam int SHORT_ITERS = 3;
    localparam int ANG_Q_W = 3;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_X_OFS = 3'd0;
    localparam logic [2:0] REG_X_SPAN = 3'd1;
    localparam logic [2:0] REG_Z_OFS = 3'd2;
    localparam logic [2:0] REG_Z_SPAN = 3'd3;
    localparam logic [2:0] REG_PERP = 3'd4;

    localparam logic signed [OFS_W-1:0] X_OFS_RST = 13'sd1050;
    localparam logic [SPAN_W-1:0] X_SPAN_RST = 13'd1485;
    localparam logic signed [OFS_W-1:0] Z_OFS_RST = 13'sd1000;
    localparam logic [SPAN_W-1:0] Z_SPAN_RST = 13'd3391;

    localparam int NEAR = 300;
    localparam int SPAN_BIAS = 500;
    localparam int SPEED_SCALE = 100;
    localparam int NEAR_SPEED = -15;
    localparam int SLEW_UP = 15;
    localparam int SLEW_DN = 30;
    localparam int SPEED_MAX = 100;
    localparam int DEAD_BAND = 10;
    localparam int ANGLE_MAX = 7;
    localparam int ANGLE_SCALE = 14;

    typedef struct packed {
        logic signed [OFS_W-1:0] x_ofs;
        logic [SPAN_W-1:0] x_span;
        logic signed [OFS_W-1:0] z_ofs;
        logic [SPAN_W-1:0] z_span;
        logic perp;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic short_mode;
        logic [DVD_W-1:0] dividend;
        logic [SPAN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

>>> hdl/fts_ifs.sv
// valid/ready channel interfaces for target items and command items
`timescale 1ns / 1ps
`default_nettype none
interface fts_tgt_if #(
    parameter int COORD_BITS = fts_pkg::COORD_BITS_DEF
);
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic confident;

    modport source(output valid, pos_x, pos_y, pos_z, confident, input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, confident, output ready);
endinterface

interface fts_cmd_if;
    logic valid;
    logic ready;
    logic signed [fts_pkg::SPD_W-1:0] speed_cmd;
    logic signed [fts_pkg::ANG_W-1:0] angle_cmd;

    modport source(output valid, speed_cmd, angle_cmd, input ready);
    modport sink(input valid, speed_cmd, angle_cmd, output ready);
endinterface
`default_nettype wire

>>> hdl/fts_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module fts_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  fts_pkg::t_div_req i_req,
    output fts_pkg::t_div_rsp o_rsp
);
    localparam int DW = fts_pkg::DVD_W;
    localparam int SW = fts_pkg::SPAN_W;
    localparam int CW = fts_pkg::CNT_W;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [SW-1:0] r_dvs, n_dvs;
    logic [SW:0]   w_trial;
    logic [SW:0]   w_diff;
    logic          w_ge;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_ge = w_trial >= {1'b0, r_dvs};
    assign w_diff = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        n_dvs = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_dvs = i_req.divisor;
            if (i_req.short_mode) begin
                n_cnt = CW'(fts_pkg::SHORT_ITERS);
                n_rem = i_req.dividend[SW+fts_pkg::SHORT_ITERS-1:fts_pkg::SHORT_ITERS];
                n_quo = {i_req.dividend[fts_pkg::SHORT_ITERS-1:0],
                         {(DW-fts_pkg::SHORT_ITERS){1'b0}}};
            end else begin
                n_cnt = CW'(DW);
                n_rem = '0;
                n_quo = i_req.dividend;
            end
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[SW-1:0] : w_trial[SW-1:0];
            n_quo = {r_quo[DW-2:0], w_ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

>>> hdl/fts_cfg.sv
// apb register bank for offsets, spans and perpendicular mode
`timescale 1ns / 1ps
`default_nettype none
module fts_cfg (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [fts_pkg::APB_AW-1:0]    paddr,
    input  wire [fts_pkg::APB_DW-1:0]    pwdata,
    output logic [fts_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output fts_pkg::t_cfg                o_cfg
);
    localparam int DW = fts_pkg::APB_DW;
    localparam int SW = fts_pkg::SPAN_W;
    localparam int OW = fts_pkg::OFS_W;

    fts_pkg::t_cfg r_cfg, n_cfg;
    logic [2:0]    w_idx;
    logic          w_wr;

    assign w_idx = paddr[fts_pkg::APB_AW-1:2];
    assign w_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                fts_pkg::REG_X_OFS:  n_cfg.x_ofs = pwdata[OW-1:0];
                fts_pkg::REG_X_SPAN: n_cfg.x_span = pwdata[SW-1:0];
                fts_pkg::REG_Z_OFS:  n_cfg.z_ofs = pwdata[OW-1:0];
                fts_pkg::REG_Z_SPAN: n_cfg.z_span = pwdata[SW-1:0];
                fts_pkg::REG_PERP:   n_cfg.perp = pwdata[0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            fts_pkg::REG_X_OFS:  prdata = {{(DW-OW){r_cfg.x_ofs[OW-1]}}, r_cfg.x_ofs};
            fts_pkg::REG_X_SPAN: prdata = {{(DW-SW){1'b0}}, r_cfg.x_span};
            fts_pkg::REG_Z_OFS:  prdata = {{(DW-OW){r_cfg.z_ofs[OW-1]}}, r_cfg.z_ofs};
            fts_pkg::REG_Z_SPAN: prdata = {{(DW-SW){1'b0}}, r_cfg.z_span};
            fts_pkg::REG_PERP:   prdata = {{(DW-1){1'b0}}, r_cfg.perp};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_ofs <= fts_pkg::X_OFS_RST;
            r_cfg.x_span <= fts_pkg::X_SPAN_RST;
            r_cfg.z_ofs <= fts_pkg::Z_OFS_RST;
            r_cfg.z_span <= fts_pkg::Z_SPAN_RST;
            r_cfg.perp <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

>>> hdl/follow_target_speed_steer.sv
// top level of the target follower: speed and steering from a tracked position
//
// i_tgt carries one target item (pos_x, pos_y, pos_z, confident) per valid/ready
// handshake; o_cmd carries one command item (speed_cmd, angle_cmd).
// the apb port (psel .. pready) sets offsets, spans and perpendicular mode;
// pready is always high, write only while no item is in flight.
// an item equal to the last stored position is taken and gives no command.
// any other item holds the input closed until its command is finished: a
// setup step, a 20-bit bit-serial division for speed and a wait for its done,
// a setup step, a 3-bit short division for the angle and a wait for its done,
// and a finish step; both divisions use the single shared divider. an item
// that needs no division skips the wait for it.
// an item without confidence clears the speed filter and gives no command.
// a new item is accepted while a finished command still waits in the output
// register; the finish step holds until that register is free, so a stalled
// receiver stalls the block after at most one more item.
// reset restores the register defaults, clears the stored position, the speed
// filter and the output valid.
`timescale 1ns / 1ps
`default_nettype none
module follow_target_speed_steer #(
    parameter int COORD_BITS = fts_pkg::COORD_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    fts_tgt_if.sink                    i_tgt,
    fts_cmd_if.source                  o_cmd,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [fts_pkg::APB_AW-1:0]  paddr,
    input  wire [fts_pkg::APB_DW-1:0]  pwdata,
    output logic [fts_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    localparam int CB = COORD_BITS;
    localparam int LW = COORD_BITS + 2;
    localparam int SW = fts_pkg::SPAN_W;
    localparam int OW = fts_pkg::OFS_W;
    localparam int DW = fts_pkg::DVD_W;
    localparam int PW = fts_pkg::SPD_W;
    localparam int AW = fts_pkg::ANG_W;
    localparam int QW = fts_pkg::ANG_Q_W;
    localparam int NW = SW + 4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SPD = 3'd1;
    localparam logic [2:0] S_SPDW = 3'd2;
    localparam logic [2:0] S_ANG = 3'd3;
    localparam logic [2:0] S_ANGW = 3'd4;
    localparam logic [2:0] S_FIN = 3'd5;

    localparam logic signed [LW-1:0] NEAR_L = LW'(fts_pkg::NEAR);
    localparam logic signed [PW-1:0] NEAR_SPD = PW'(fts_pkg::NEAR_SPEED);
    localparam logic signed [PW-1:0] SPD_MAX = PW'(fts_pkg::SPEED_MAX);
    localparam logic signed [PW-1:0] SPD_MIN = PW'(-fts_pkg::SPEED_MAX);
    localparam logic signed [PW-1:0] SPD_DEAD = PW'(fts_pkg::DEAD_BAND);
    localparam logic signed [PW-1:0] SPD_POS_SAT = PW'(127);
    localparam logic signed [PW-1:0] SPD_NEG_SAT = PW'(-128);
    localparam logic signed [PW+1:0] UP_L = (PW+2)'(fts_pkg::SLEW_UP);
    localparam logic signed [PW+1:0] DN_L = (PW+2)'(-fts_pkg::SLEW_DN);
    localparam logic signed [AW-1:0] ANG_POS = AW'(fts_pkg::ANGLE_MAX);
    localparam logic signed [AW-1:0] ANG_NEG = AW'(-fts_pkg::ANGLE_MAX);

    fts_pkg::t_cfg     w_cfg;
    fts_pkg::t_div_req w_req;
    fts_pkg::t_div_rsp w_rsp;

    logic [2:0]             r_state, n_state;
    logic [CB-1:0]          r_last_x, r_last_y, r_last_z;
    logic signed [PW-1:0]   r_filt, n_filt;
    logic                   r_out_vld, n_out_vld;
    logic signed [PW-1:0]   r_out_spd, n_out_spd;
    logic signed [AW-1:0]   r_out_ang, n_out_ang;

    logic signed [LW-1:0]   r_lat, r_dep;
    logic [SW-1:0]          r_lspan, r_dspan;
    logic                   r_conf;
    logic                   r_dneg, n_dneg;
    logic                   r_neg, n_neg;
    logic signed [PW-1:0]   r_spd, n_spd;
    logic signed [AW-1:0]   r_ang, n_ang;

    logic                   w_acc, w_same;
    logic signed [LW-1:0]   w_lat, w_dep;
    logic signed [LW-1:0]   w_dspan_l, w_lspan_l;
    logic [SW-1:0]          w_dmin;
    logic [DW-1:0]          w_num;
    logic signed [SW:0]     w_den;
    logic [SW:0]            w_den_mag;
    logic [NW-1:0]          w_7l, w_14l, w_an, w_an_mag;
    logic [SW-1:0]          w_l;
    logic [DW-1:0]          w_q;
    logic signed [PW-1:0]   w_f0, w_f, w_o;
    logic signed [PW+1:0]   w_diff;
    logic                   w_slot;

    fts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign i_tgt.ready = (r_state == S_IDLE);
    assign w_acc = i_tgt.valid && i_tgt.ready;
    assign w_same = (i_tgt.pos_x == r_last_x) && (i_tgt.pos_y == r_last_y)
                    && (i_tgt.pos_z == r_last_z);

    assign w_lat = {{2{i_tgt.pos_x[CB-1]}}, i_tgt.pos_x}
                   + {{(LW-OW){w_cfg.x_ofs[OW-1]}}, w_cfg.x_ofs};
    assign w_dep = {{2{i_tgt.pos_z[CB-1]}}, i_tgt.pos_z}
                   - {{(LW-OW){w_cfg.z_ofs[OW-1]}}, w_cfg.z_ofs};

    // speed terms
    assign w_dspan_l = {{(LW-SW){1'b0}}, r_dspan};
    assign w_dmin = r_dep[SW-1:0] - SW'(fts_pkg::NEAR);
    assign w_num = DW'(w_dmin) * DW'(fts_pkg::SPEED_SCALE);
    assign w_den = $signed({1'b0, r_dspan}) - (SW+1)'(fts_pkg::SPAN_BIAS);
    assign w_den_mag = w_den[SW] ? (SW+1)'(-w_den) : w_den;

    // angle terms
    assign w_lspan_l = {{(LW-SW){1'b0}}, r_lspan};
    assign w_l = r_lat[SW-1:0];
    assign w_7l = NW'(r_lspan) * NW'(fts_pkg::ANGLE_MAX);
    assign w_14l = NW'(w_l) * NW'(fts_pkg::ANGLE_SCALE);
    assign w_an = w_7l - w_14l;
    assign w_an_mag = w_an[NW-1] ? NW'(-w_an) : w_an;

    assign w_q = w_rsp.quotient;

    // slew limit and output shaping
    assign w_f0 = r_dneg ? '0 : r_filt;
    assign w_diff = (PW+2)'(r_spd) - (PW+2)'(w_f0);
    assign w_slot = !r_out_vld || o_cmd.ready;

    always_comb begin
        if (w_diff > UP_L) begin
            w_f = w_f0 + PW'(fts_pkg::SLEW_UP);
        end else if (w_diff < DN_L) begin
            w_f = w_f0 - PW'(fts_pkg::SLEW_DN);
        end else begin
            w_f = r_spd;
        end
        if (w_f > SPD_MAX) begin
            w_o = SPD_MAX;
        end else if (w_f < SPD_MIN) begin
            w_o = SPD_MIN;
        end else if (w_f >= 0 && w_f < SPD_DEAD) begin
            w_o = '0;
        end else begin
            w_o = w_f;
        end
    end

    always_comb begin
        n_state = r_state;
        n_filt = r_filt;
        n_out_vld = r_out_vld && !o_cmd.ready;
        n_out_spd = r_out_spd;
        n_out_ang = r_out_ang;
        n_dneg = r_dneg;
        n_neg = r_neg;
        n_spd = r_spd;
        n_ang = r_ang;
        w_req.start = 1'b0;
        w_req.short_mode = 1'b0;
        w_req.dividend = w_num;
        w_req.divisor = w_den_mag[SW-1:0];
        case (r_state)
            S_IDLE: begin
                if (w_acc && !w_same) begin
                    n_state = S_SPD;
                end
            end
            S_SPD: begin
                n_dneg = r_dep[LW-1];
                n_state = S_ANG;
                if (r_dep[LW-1] || r_dep > w_dspan_l) begin
                    n_spd = '0;
                end else if (r_dep < NEAR_L) begin
                    n_spd = NEAR_SPD;
                end else if (w_den == '0) begin
                    n_spd = (w_dmin != '0) ? SPD_MAX : '0;
                end else begin
                    w_req.start = 1'b1;
                    n_neg = w_den[SW];
                    n_state = S_SPDW;
                end
            end
            S_SPDW: begin
                if (w_rsp.done) begin
                    if (r_neg) begin
                        n_spd = (w_q > DW'(128)) ? SPD_NEG_SAT : PW'(-w_q);
                    end else begin
                        n_spd = (w_q > DW'(127)) ? SPD_POS_SAT : PW'(w_q);
                    end
                    n_state = S_ANG;
                end
            end
            S_ANG: begin
                w_req.short_mode = 1'b1;
                w_req.dividend = DW'(w_an_mag);
                w_req.divisor = r_lspan;
                n_state = S_FIN;
                if (r_lat[LW-1]) begin
                    n_ang = ANG_POS;
                end else if (r_lat > w_lspan_l) begin
                    n_ang = ANG_NEG;
                end else if (r_lspan == '0) begin
                    n_ang = ANG_POS;
                end else begin
                    w_req.start = 1'b1;
                    n_neg = w_an[NW-1];
                    n_state = S_ANGW;
                end
            end
            S_ANGW: begin
                if (w_rsp.done) begin
                    n_ang = r_neg ? AW'(-{1'b0, w_q[QW-1:0]}) : AW'({1'b0, w_q[QW-1:0]});
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_conf) begin
                    n_filt = '0;
                    n_state = S_IDLE;
                end else if (w_slot) begin
                    n_filt = w_f;
                    n_out_vld = 1'b1;
                    n_out_spd = w_o;
                    n_out_ang = r_ang;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_filt <= '0;
            r_out_vld <= 1'b0;
            r_last_x <= '0;
            r_last_y <= '0;
            r_last_z <= '0;
        end else begin
            r_state <= n_state;
            r_filt <= n_filt;
            r_out_vld <= n_out_vld;
            if (w_acc && !w_same) begin
                r_last_x <= i_tgt.pos_x;
                r_last_y <= i_tgt.pos_y;
                r_last_z <= i_tgt.pos_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_spd <= n_out_spd;
        r_out_ang <= n_out_ang;
        r_dneg <= n_dneg;
        r_neg <= n_neg;
        r_spd <= n_spd;
        r_ang <= n_ang;
        if (w_acc && !w_same) begin
            r_conf <= i_tgt.confident;
            if (w_cfg.perp) begin
                r_lat <= w_dep;
                r_dep <= w_lat;
                r_lspan <= w_cfg.z_span;
                r_dspan <= w_cfg.x_span;
            end else begin
                r_lat <= w_lat;
                r_dep <= w_dep;
                r_lspan <= w_cfg.x_span;
                r_dspan <= w_cfg.z_span;
            end
        end
    end

    assign o_cmd.valid = r_out_vld;
    assign o_cmd.speed_cmd = r_out_spd;
    assign o_cmd.angle_cmd = r_out_ang;
endmodule
`default_nettype wire

>>> hdl/fts_chk.sv
// port-level checker for the target follower, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module fts_chk (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_out_valid,
    input wire                              i_out_ready,
    input wire signed [fts_pkg::SPD_W-1:0]  i_speed_cmd,
    input wire signed [fts_pkg::ANG_W-1:0]  i_angle_cmd,
    input wire                              i_pready
);
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_speed_cmd)
            && $stable(i_angle_cmd))
        else $error("stalled command item changed");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_speed_cmd <= 8'sd100 && i_speed_cmd >= -8'sd100
            && !(i_speed_cmd > 8'sd0 && i_speed_cmd < 8'sd10))
        else $error("speed outside clamp or in dead band");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_angle_cmd <= 4'sd7 && i_angle_cmd >= -4'sd7)
        else $error("angle outside range");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");
endmodule

bind follow_target_speed_steer fts_chk u_fts_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_cmd.valid),
    .i_out_ready (o_cmd.ready),
    .i_speed_cmd (o_cmd.speed_cmd),
    .i_angle_cmd (o_cmd.angle_cmd),
    .i_pready    (pready)
);
`default_nettype wire
